// ===== src/ukpg_pkg.sv =====
package ukpg_pkg;

    // Default sizing of the value store
    localparam int MAX_ELEMENTS_DEF = 8;
    localparam int VALUE_BITS_DEF   = 16;

    // Longest arrangement the position field can express
    localparam int MAX_PICK = 8;

    // Field widths of the channels
    localparam int CFG_BITS  = 4;
    localparam int SLOT_BITS = 3;
    localparam int POS_BITS  = 3;
    localparam int IO_BITS   = 16;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_NEXT = 1'b1
    } t_op;

    typedef enum logic {
        REG_ELEMENT_COUNT = 1'b0,
        REG_PICK_LENGTH   = 1'b1
    } t_reg;

    typedef enum logic [1:0] {
        PH_NEEDS_SORT,
        PH_RUNNING,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT,
        ST_RESUME,
        ST_SCAN,
        ST_EMIT,
        ST_EXHAUST
    } t_state;

    typedef struct packed {
        t_op                         operation;
        logic [SLOT_BITS-1:0]        slot;
        logic signed [IO_BITS-1:0]   load_value;
    } t_in;

    typedef struct packed {
        logic signed [IO_BITS-1:0]   element_value;
        logic [POS_BITS-1:0]         position;
        logic                        last_element;
        logic                        exhausted;
    } t_out;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic sort_init;
        logic sort_step;
        logic fresh;
        logic resume;
        logic skip;
        logic take;
        logic descend;
        logic back;
        logic emit;
        logic exhaust;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic cfg_hit;
        logic slot_hit;
        logic sort_last;
        logic len_bad;
        logic scan_end;
        logic scan_hit;
        logic lvl_last;
        logic lvl_zero;
        logic pos_last;
        logic out_free;
    } t_status;

endpackage

// ===== src/ukpg_datapath.sv =====
module ukpg_datapath
    import ukpg_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int VALUE_BITS   = VALUE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_in                 i_in_data,
    input  logic                i_cfg_we,
    input  t_reg                i_cfg_index,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output t_out                o_out_data
);

    localparam int IW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    logic signed [VALUE_BITS-1:0] r_val [MAX_ELEMENTS];
    logic signed [VALUE_BITS-1:0] w_sorted [MAX_ELEMENTS];
    logic [IW-1:0]                r_stack [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0]      r_used;
    logic [MAX_ELEMENTS-1:0]      w_eq;
    logic [IW-1:0]                r_lvl;
    logic [IW-1:0]                r_pass;
    logic [CW-1:0]                r_i;
    logic                         r_in_run;
    logic [POS_BITS-1:0]          r_pos;
    logic [CFG_BITS-1:0]          r_cnt;
    logic [CFG_BITS-1:0]          r_len;
    logic                         r_out_valid;
    t_out                         r_out;

    logic [CW-1:0] w_n;
    logic [IW-1:0] w_i_idx;
    logic [IW-1:0] w_rd_idx;
    logic [IW-1:0] w_slot;
    logic [IW-1:0] w_load_idx;

    // Effective count saturates at the store depth
    assign w_n        = (int'(r_cnt) > MAX_ELEMENTS) ? CW'(MAX_ELEMENTS) : CW'(r_cnt);
    assign w_i_idx    = IW'(r_i);
    assign w_rd_idx   = i_cmd.emit ? IW'(r_pos) : r_lvl;
    assign w_slot     = r_stack[w_rd_idx];
    assign w_load_idx = IW'(i_in_data.slot);

    // Neighbor equality of the sorted values
    always_comb begin
        w_eq = '0;
        for (int j = 0; j < MAX_ELEMENTS - 1; j++) begin
            w_eq[j] = (r_val[j] == r_val[j + 1]);
        end
    end

    // One odd-even transposition pass over the active slots
    always_comb begin
        for (int j = 0; j < MAX_ELEMENTS; j++) begin
            w_sorted[j] = r_val[j];
        end
        for (int j = 0; j < MAX_ELEMENTS - 1; j++) begin
            if ((j % 2) == int'(r_pass[0]) && (j + 1) < int'(w_n)
                    && r_val[j] > r_val[j + 1]) begin
                w_sorted[j]     = r_val[j + 1];
                w_sorted[j + 1] = r_val[j];
            end
        end
    end

    always_comb begin
        o_status.cfg_hit   = i_cfg_we;
        o_status.slot_hit  = (int'(i_in_data.slot) < MAX_ELEMENTS);
        o_status.sort_last = (r_pass == IW'(MAX_ELEMENTS - 1));
        o_status.len_bad   = (w_n == '0) || (r_len == '0) || (int'(r_len) > int'(w_n))
                             || (int'(r_len) > MAX_PICK);
        o_status.scan_end  = (r_i >= w_n);
        o_status.scan_hit  = !r_used[w_i_idx] && !r_in_run;
        o_status.lvl_last  = (int'(r_lvl) + 1 == int'(r_len));
        o_status.lvl_zero  = (r_lvl == '0);
        o_status.pos_last  = (int'(r_pos) + 1 == int'(r_len));
        o_status.out_free  = !r_out_valid || !i_out_stall;
    end

    // Value store: written by loads and by the sort
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && o_status.slot_hit) begin
            r_val[w_load_idx] <= VALUE_BITS'(i_in_data.load_value);
        end else if (i_cmd.sort_step) begin
            r_val <= w_sorted;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CFG_BITS'(MAX_PICK);
            r_len <= CFG_BITS'(MAX_PICK);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ELEMENT_COUNT: r_cnt <= i_cfg_data;
                REG_PICK_LENGTH:   r_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Search state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_lvl    <= '0;
            r_pass   <= '0;
            r_i      <= '0;
            r_in_run <= 1'b0;
            r_pos    <= '0;
            for (int j = 0; j < MAX_ELEMENTS; j++) begin
                r_stack[j] <= '0;
            end
        end else begin
            if (i_cmd.sort_init) begin
                r_used <= '0;
                r_lvl  <= '0;
                r_pass <= '0;
            end
            if (i_cmd.sort_step) begin
                r_pass <= r_pass + IW'(1);
            end
            if (i_cmd.fresh) begin
                r_i      <= '0;
                r_in_run <= 1'b0;
            end
            if (i_cmd.resume) begin
                r_used[w_slot] <= 1'b0;
                r_i            <= CW'(w_slot) + CW'(1);
                r_in_run       <= w_eq[w_slot];
            end
            if (i_cmd.skip) begin
                r_i      <= r_i + CW'(1);
                r_in_run <= r_in_run & w_eq[w_i_idx];
            end
            if (i_cmd.take) begin
                r_stack[r_lvl]  <= w_i_idx;
                r_used[w_i_idx] <= 1'b1;
            end
            if (i_cmd.descend) begin
                r_lvl    <= r_lvl + IW'(1);
                r_i      <= '0;
                r_in_run <= 1'b0;
            end
            if (i_cmd.back) begin
                r_lvl <= r_lvl - IW'(1);
            end
            if (i_cmd.emit) begin
                r_pos <= o_status.pos_last ? '0 : r_pos + POS_BITS'(1);
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.exhaust) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.element_value <= IO_BITS'(r_val[w_slot]);
            r_out.position      <= r_pos;
            r_out.last_element  <= o_status.pos_last;
            r_out.exhausted     <= 1'b0;
        end else if (i_cmd.exhaust) begin
            r_out.element_value <= '0;
            r_out.position      <= '0;
            r_out.last_element  <= 1'b0;
            r_out.exhausted     <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== src/ukpg_ctrl.sv =====
module ukpg_ctrl
    import ukpg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_op     i_op,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   w_accept;

    assign w_accept = i_in_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_NEEDS_SORT;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    // Next state and enumeration phase
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_op == OP_LOAD) begin
                        if (i_status.slot_hit) begin
                            n_phase = PH_NEEDS_SORT;
                        end
                    end else begin
                        unique case (r_phase)
                            PH_NEEDS_SORT: n_state = ST_SORT;
                            PH_RUNNING:    n_state = ST_RESUME;
                            default:       n_state = ST_EXHAUST;
                        endcase
                    end
                end
            end
            ST_SORT: begin
                if (i_status.sort_last) begin
                    n_state = i_status.len_bad ? ST_EXHAUST : ST_SCAN;
                end
            end
            ST_RESUME: n_state = ST_SCAN;
            ST_SCAN: begin
                if (i_status.scan_end) begin
                    n_state = i_status.lvl_zero ? ST_EXHAUST : ST_RESUME;
                end else if (i_status.scan_hit && i_status.lvl_last) begin
                    n_state = ST_EMIT;
                    n_phase = PH_RUNNING;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free && i_status.pos_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EXHAUST: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                    n_phase = PH_DONE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (i_status.cfg_hit) begin
            n_phase = PH_NEEDS_SORT;
        end
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_op == OP_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else if (r_phase == PH_NEEDS_SORT) begin
                        o_cmd.sort_init = 1'b1;
                    end
                end
            end
            ST_SORT: begin
                o_cmd.sort_step = 1'b1;
                o_cmd.fresh     = i_status.sort_last && !i_status.len_bad;
            end
            ST_RESUME: o_cmd.resume = 1'b1;
            ST_SCAN: begin
                if (i_status.scan_end) begin
                    o_cmd.back = !i_status.lvl_zero;
                end else if (i_status.scan_hit) begin
                    o_cmd.take    = 1'b1;
                    o_cmd.descend = !i_status.lvl_last;
                end else begin
                    o_cmd.skip = 1'b1;
                end
            end
            ST_EMIT:    o_cmd.emit    = i_status.out_free;
            ST_EXHAUST: o_cmd.exhaust = i_status.out_free;
            default: ;
        endcase
    end

endmodule

// ===== src/unique_k_permutation_generator.sv =====
// Distinct k-length arrangements of a small loaded multiset.
//
// Request channel (i_in_valid / o_in_stall / i_in_data): a load request
// writes one signed value into a slot and restarts the enumeration; a next
// request produces the next distinct arrangement. Result channel
// (o_out_valid / i_out_stall / o_out_data): one result per element, in
// position order, with last_element set on the final one. When nothing is
// left a single result with exhausted set and zero value fields is given.
// Configuration port (i_cfg_we / i_cfg_index / i_cfg_data): element_count
// and pick_length; a write restarts the enumeration. Write only while idle.
//
// A load is written into the store as it is accepted. A next request runs
// the search in a single-step scan unit, one slot tested per cycle: the
// first request after a restart sorts the store by odd-even transposition,
// then slot tests, backtracks and resumes follow, and the k results leave
// one per cycle through the output register unless the result side stalls.
// One request is taken at a time, the next once the last result is
// registered. Reset restores both registers to 8, clears the search and
// leaves the store unwritten. A stall on the result side holds the output
// register and freezes the emit sequence until the result is taken.
module unique_k_permutation_generator
    import ukpg_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int VALUE_BITS   = VALUE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in                 i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out                o_out_data,
    input  logic                i_cfg_we,
    input  t_reg                i_cfg_index,
    input  logic [CFG_BITS-1:0] i_cfg_data
);

    // Command and status between sequencer and datapath
    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer: decode requests, step sort/scan/emit, track enumeration phase
    ukpg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_data.operation),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath: value store, sorter, slot stack, scan unit, output register
    ukpg_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .VALUE_BITS   (VALUE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
